/* hw/rtl/rlsa_pkg.sv */
`default_nettype none

package rlsa_pkg;

  // Field widths fixed by the interface.
  localparam int TIME_W     = 32;
  localparam int SAMPLE_W   = 32;
  localparam int INTERVAL_W = 16;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_INDEX_W = 1;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_POLL_INTERVAL = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_STALE_TIMEOUT = 1'b1;

  // Reset values of the configuration registers.
  localparam logic [INTERVAL_W-1:0] POLL_INTERVAL_RESET = 16'd12;
  localparam logic [TIME_W-1:0]     STALE_TIMEOUT_RESET = 32'd100;

  typedef logic [TIME_W-1:0]          time_ms_t;
  typedef logic signed [SAMPLE_W-1:0] sample_t;

endpackage

`default_nettype wire

/* hw/rtl/rlsa_ring_mem.sv */
`default_nettype none

module rlsa_ring_mem
  import rlsa_pkg::*;
#(
  parameter int DEPTH  = 8,
  parameter int ADDR_W = 3
) (
  input  wire logic              clk,
  input  wire logic              write_en,
  input  wire logic [ADDR_W-1:0] write_addr,
  input  wire sample_t           write_data,
  input  wire logic [ADDR_W-1:0] read_addr,
  output sample_t                read_data
);

  sample_t mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (write_en) begin
      mem[write_addr] <= write_data;
    end
    read_data <= mem[read_addr];
  end

endmodule

`default_nettype wire

/* hw/rtl/rlsa_divider.sv */
`default_nettype none

module rlsa_divider
  import rlsa_pkg::*;
#(
  parameter int QUO_W   = 36,
  parameter int COUNT_W = 4
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic [QUO_W-1:0]   dividend,
  input  wire logic [COUNT_W-1:0] divisor,
  output logic                    done,
  output logic [QUO_W-1:0]        quotient
);

  // Two restoring steps per cycle over an even-width dividend.
  localparam int STEPS = QUO_W / 2;
  localparam int CNT_W = $clog2(STEPS + 1);

  logic               busy;
  logic [CNT_W-1:0]   cnt;
  logic [COUNT_W-1:0] rem;
  logic [COUNT_W-1:0] rem_next;
  logic [QUO_W-1:0]   quo_next;

  logic [COUNT_W:0]   trial_a;
  logic [COUNT_W:0]   trial_b;
  logic               fits_a;
  logic               fits_b;
  logic [COUNT_W-1:0] rem_a;
  logic [QUO_W-1:0]   quo_a;

  // Shift in the next dividend bit, subtract the divisor where it fits.
  always_comb begin
    trial_a  = {rem, quotient[QUO_W-1]};
    fits_a   = (trial_a >= {1'b0, divisor});
    rem_a    = fits_a ? COUNT_W'(trial_a - {1'b0, divisor}) : COUNT_W'(trial_a);
    quo_a    = {quotient[QUO_W-2:0], fits_a};
    trial_b  = {rem_a, quo_a[QUO_W-1]};
    fits_b   = (trial_b >= {1'b0, divisor});
    rem_next = fits_b ? COUNT_W'(trial_b - {1'b0, divisor}) : COUNT_W'(trial_b);
    quo_next = {quo_a[QUO_W-2:0], fits_b};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        cnt      <= CNT_W'(STEPS);
        rem      <= '0;
        quotient <= dividend;
      end else if (busy) begin
        rem      <= rem_next;
        quotient <= quo_next;
        cnt      <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/rate_limited_sample_averager_core.sv */
`default_nettype none

// Rate-limited force averager over a ring of recent samples.
//
// Input channel (in_valid/in_ready) carries one poll opportunity: a time
// stamp, a read status and force and displacement samples in Q16.16. The
// poll is taken when at least poll_interval_ms have passed since the last
// taken poll; a taken poll with a good read writes the force sample into
// the ring memory and latches the displacement.
// Output channel (out_valid/out_ready) returns exactly one result per
// input transfer: the taken and stored flags, the mean of the filled ring
// entries, the held displacement, the stale flag and the fill count.
// One item is worked on at a time: the ring is summed one memory read per
// cycle, then a two-bit-per-cycle divider runs; with an empty ring both
// steps are skipped. The next item may follow once the result has moved
// into the output register. in_ready is high only while no item is in
// progress. The output register lets a new item be accepted while a
// result waits; if that result is still not taken when the next one is
// done, the block holds the new one.
// Synchronous reset clears the time stamps, fill count, write slot and
// held displacement and loads the register defaults; ring contents are
// left as they are and never read before being written.
module rate_limited_sample_averager_core
  import rlsa_pkg::*;
#(
  parameter int RING_DEPTH = 8,
  localparam int COUNT_W   = $clog2(RING_DEPTH + 1)
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_write,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire time_ms_t               now_ms,
  input  wire logic                   read_ok,
  input  wire sample_t                force_sample,
  input  wire sample_t                displacement_sample,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic                        poll_taken,
  output logic                        sample_stored,
  output sample_t                     average_force,
  output sample_t                     latest_displacement,
  output logic                        stale,
  output logic [COUNT_W-1:0]          samples_held
);

  localparam int ADDR_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int SUM_W  = SAMPLE_W + $clog2(RING_DEPTH);
  localparam int QUO_W  = 2 * ((SUM_W + 1) / 2);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_DIV,
    ST_DONE
  } state_t;

  state_t state;

  // Configuration registers.
  logic [INTERVAL_W-1:0] poll_interval_ms;
  time_ms_t              stale_timeout_ms;

  // Block state outside the ring.
  logic [ADDR_W-1:0]  write_slot;
  logic [COUNT_W-1:0] fill_count;
  sample_t            held_displacement;
  time_ms_t           last_poll_time;
  time_ms_t           last_valid_time;

  // Result under construction.
  logic pend_taken;
  logic pend_stored;
  logic pend_stale;

  // Summation sequencer.
  logic [COUNT_W-1:0]      rd_idx;
  logic                    rd_pend;
  logic signed [SUM_W-1:0] acc;
  sample_t                 rd_data;

  // Divider connections.
  logic             div_start;
  logic             div_done;
  logic [QUO_W-1:0] div_quotient;
  logic             acc_neg;
  logic [SUM_W-1:0] acc_mag;
  logic [SAMPLE_W-1:0] quo_low;

  // Poll decision for the item on the input.
  logic               in_xfer;
  logic               taken;
  logic               stored;
  logic [COUNT_W-1:0] fill_count_next;
  time_ms_t           valid_time_next;
  logic               stale_next;
  logic               out_free;

  assign in_ready = (state == ST_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    taken  = (TIME_W'(now_ms - last_poll_time) >= TIME_W'(poll_interval_ms));
    stored = taken && read_ok;
    fill_count_next = (stored && (fill_count < COUNT_W'(RING_DEPTH))) ?
                      COUNT_W'(fill_count + 1'b1) : fill_count;
    valid_time_next = stored ? now_ms : last_valid_time;
    stale_next      = (TIME_W'(now_ms - valid_time_next) > stale_timeout_ms);
  end

  // Magnitude of the sum for the unsigned divider.
  always_comb begin
    acc_neg = acc[SUM_W-1];
    acc_mag = acc_neg ? SUM_W'(-acc) : SUM_W'(acc);
    quo_low = div_quotient[SAMPLE_W-1:0];
  end

  rlsa_ring_mem #(
    .DEPTH  (RING_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_ring (
    .clk        (clk),
    .write_en   (in_xfer && stored),
    .write_addr (write_slot),
    .write_data (force_sample),
    .read_addr  (rd_idx[ADDR_W-1:0]),
    .read_data  (rd_data)
  );

  rlsa_divider #(
    .QUO_W   (QUO_W),
    .COUNT_W (COUNT_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (QUO_W'(acc_mag)),
    .divisor  (fill_count),
    .done     (div_done),
    .quotient (div_quotient)
  );

  // Configuration writes; out-of-range indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      poll_interval_ms <= POLL_INTERVAL_RESET;
      stale_timeout_ms <= STALE_TIMEOUT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_POLL_INTERVAL: poll_interval_ms <= cfg_data[INTERVAL_W-1:0];
        REG_STALE_TIMEOUT: stale_timeout_ms <= cfg_data[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer: update on transfer, sum the ring, divide, present result.
  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_IDLE;
      write_slot        <= '0;
      fill_count        <= '0;
      held_displacement <= '0;
      last_poll_time    <= '0;
      last_valid_time   <= '0;
      out_valid         <= 1'b0;
      div_start         <= 1'b0;
      rd_idx            <= '0;
      rd_pend           <= 1'b0;
    end else begin
      div_start <= 1'b0;
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_xfer) begin
            pend_taken  <= taken;
            pend_stored <= stored;
            pend_stale  <= stale_next;
            fill_count  <= fill_count_next;
            if (taken) begin
              last_poll_time <= now_ms;
            end
            if (stored) begin
              held_displacement <= displacement_sample;
              last_valid_time   <= now_ms;
              write_slot <= (write_slot == ADDR_W'(RING_DEPTH - 1)) ?
                            '0 : ADDR_W'(write_slot + 1'b1);
            end
            acc     <= '0;
            rd_idx  <= '0;
            rd_pend <= 1'b0;
            state   <= (fill_count_next == '0) ? ST_DONE : ST_SUM;
          end
        end
        ST_SUM: begin
          // Address issued this cycle returns data in the next one.
          rd_pend <= (rd_idx < fill_count);
          if (rd_idx < fill_count) begin
            rd_idx <= COUNT_W'(rd_idx + 1'b1);
          end
          if (rd_pend) begin
            acc <= acc + SUM_W'(rd_data);
          end
          if (!rd_pend && (rd_idx == fill_count)) begin
            div_start <= 1'b1;
            state     <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            acc   <= SUM_W'(signed'(acc_neg ? -quo_low : quo_low));
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid           <= 1'b1;
            poll_taken          <= pend_taken;
            sample_stored       <= pend_stored;
            average_force       <= acc[SAMPLE_W-1:0];
            latest_displacement <= held_displacement;
            stale               <= pend_stale;
            samples_held        <= fill_count;
            state               <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // A stored sample always belongs to a taken poll.
  a_stored_taken: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!sample_stored || poll_taken))
    else $error("stored sample without taken poll");

  // A freshly stored sample is never stale.
  a_stored_fresh: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!sample_stored || !stale))
    else $error("stored sample reported stale");

  // The fill count never passes the ring depth.
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= COUNT_W'(RING_DEPTH))
    else $error("fill count beyond ring depth");

  // The divider only finishes while the sequencer waits for it.
  a_div_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_DIV))
    else $error("divider finished outside divide phase");

endmodule

`default_nettype wire
